// File: sv/ipv4_text_finder_assert.svh
// assertion macros for the checker module
`ifndef IPV4_TEXT_FINDER_ASSERT_SVH
`define IPV4_TEXT_FINDER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ITF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itf check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define ITF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itf check failed");

`endif

// File: sv/itf_pkg.sv
package itf_pkg;

    localparam int ByteW  = 8;
    localparam int AddrW  = 32;

    localparam logic [ByteW-1:0] CharZero = 8'h30;
    localparam logic [ByteW-1:0] CharNine = 8'h39;
    localparam logic [ByteW-1:0] CharDot  = 8'h2E;

    localparam logic [9:0] OctetMax     = 10'd255;
    localparam logic [4:0] RunMax       = 5'd15;
    localparam logic [4:0] RunMin       = 5'd7;
    localparam logic [4:0] RunSat       = 5'd16;
    localparam logic [1:0] SegDigitsMax = 2'd3;
    localparam logic [2:0] SegLast      = 3'd3;   // segments closed by inner dots in an address
    localparam logic [3:0] DotsSat      = 4'd15;

    typedef struct packed {
        logic        in_run;
        logic [4:0]  run_length;
        logic [2:0]  segment_count;
        logic [9:0]  segment_value;
        logic [1:0]  segment_digits;
        logic [3:0]  pending_dots;
        logic        run_invalid;
        logic [23:0] octet_store;
        logic        already_found;
    } scan_state_t;

    typedef struct packed {
        logic             emit;
        logic             found;
        logic [AddrW-1:0] address;
    } scan_result_t;

endpackage

// File: sv/itf_in_if.sv
interface itf_in_if;
    logic                      valid;
    logic                      ready;
    logic [itf_pkg::ByteW-1:0] text_byte;
    logic                      text_end;

    modport source (output valid, output text_byte, output text_end, input ready);
    modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

// File: sv/itf_out_if.sv
interface itf_out_if;
    logic                      valid;
    logic                      ready;
    logic                      found;
    logic [itf_pkg::AddrW-1:0] address;

    modport source (output valid, output found, output address, input ready);
    modport sink   (input valid, input found, input address, output ready);
endinterface

// File: sv/itf_scan.sv
module itf_scan (
    input  itf_pkg::scan_state_t       cur,
    input  logic [itf_pkg::ByteW-1:0]  text_byte,
    input  logic                       text_end,
    output itf_pkg::scan_state_t       nxt,
    output itf_pkg::scan_result_t      res
);

    logic       is_digit;
    logic       is_dot;
    logic [3:0] digit;

    assign is_digit = (text_byte >= itf_pkg::CharZero) && (text_byte <= itf_pkg::CharNine);
    assign is_dot   = (text_byte == itf_pkg::CharDot);
    assign digit    = text_byte[3:0];

    function automatic logic run_ok(input itf_pkg::scan_state_t s);
        run_ok = s.in_run && !s.run_invalid
              && (s.run_length >= itf_pkg::RunMin) && (s.run_length <= itf_pkg::RunMax)
              && (s.segment_count == itf_pkg::SegLast)
              && (s.segment_digits != 2'd0) && (s.segment_value <= itf_pkg::OctetMax);
    endfunction

    itf_pkg::scan_state_t w;
    logic                 judged;
    logic                 hit;

    always_comb
    begin
        w      = cur;
        nxt    = cur;
        res    = '0;
        judged = 1'b0;
        hit    = 1'b0;
        if (cur.already_found)
        begin
            // ignore bytes until the text ends
            if (text_end)
            begin
                nxt = '0;
            end
        end
        else
        begin
            if (is_digit)
            begin
                if (!w.in_run)
                begin
                    w                = '0;
                    w.in_run         = 1'b1;
                    w.run_length     = 5'd1;
                    w.segment_value  = {6'd0, digit};
                    w.segment_digits = 2'd1;
                end
                else
                begin
                    if (w.run_length < itf_pkg::RunSat)
                    begin
                        w.run_length = w.run_length + 5'd1;
                    end
                    if (w.pending_dots != 4'd0)
                    begin
                        // close the segment before the dots
                        if (w.pending_dots > 4'd1)
                        begin
                            w.run_invalid = 1'b1;
                        end
                        if (w.segment_value > itf_pkg::OctetMax)
                        begin
                            w.run_invalid = 1'b1;
                        end
                        if (w.segment_count >= itf_pkg::SegLast)
                        begin
                            w.run_invalid = 1'b1;
                        end
                        else
                        begin
                            w.octet_store   = {w.octet_store[15:0], w.segment_value[7:0]};
                            w.segment_count = w.segment_count + 3'd1;
                        end
                        w.segment_value  = {6'd0, digit};
                        w.segment_digits = 2'd1;
                        w.pending_dots   = 4'd0;
                    end
                    else if (w.segment_digits >= itf_pkg::SegDigitsMax)
                    begin
                        w.run_invalid = 1'b1;
                    end
                    else
                    begin
                        // times ten as two shifts
                        w.segment_value  = {w.segment_value[6:0], 3'b000}
                                         + {w.segment_value[8:0], 1'b0}
                                         + {6'd0, digit};
                        w.segment_digits = w.segment_digits + 2'd1;
                    end
                end
            end
            else if (is_dot)
            begin
                if (w.in_run)
                begin
                    if (w.run_length < itf_pkg::RunSat)
                    begin
                        w.run_length = w.run_length + 5'd1;
                    end
                    if (w.pending_dots < itf_pkg::DotsSat)
                    begin
                        w.pending_dots = w.pending_dots + 4'd1;
                    end
                end
            end
            else if (w.in_run)
            begin
                judged = 1'b1;
            end

            if (text_end && w.in_run)
            begin
                judged = 1'b1;
            end

            if (judged)
            begin
                hit = run_ok(w);
            end

            if (hit)
            begin
                res.emit          = 1'b1;
                res.found         = 1'b1;
                res.address       = {w.octet_store, w.segment_value[7:0]};
                nxt               = '0;
                nxt.already_found = !text_end;
            end
            else if (text_end)
            begin
                res.emit = 1'b1;
                nxt      = '0;
            end
            else if (judged)
            begin
                nxt = '0;
            end
            else
            begin
                nxt = w;
            end
        end
    end

endmodule

// File: sv/ipv4_text_finder.sv
// path: input register, scan logic, result register, then the output channel
// throughput: one byte per cycle unless stalled, bounded by the scan state update loop
// the input stalls only when a byte that yields a result meets a full, stalled output register
// reset: rst_n asynchronous active low; clears the scan state and both valid flags
module ipv4_text_finder (
    input  logic             clk,
    input  logic             rst_n,
    itf_in_if.sink           text,
    itf_out_if.source        result
);

    // input register: one byte waiting for the scan logic
    logic                          in_vld_reg;
    logic                          in_vld_next;
    logic [itf_pkg::ByteW-1:0]     in_byte_reg;
    logic                          in_end_reg;

    // scan state carried from byte to byte
    itf_pkg::scan_state_t          state_reg;
    itf_pkg::scan_state_t          state_next;

    // result register
    logic                          out_vld_reg;
    logic                          out_vld_next;
    logic                          out_found_reg;
    logic [itf_pkg::AddrW-1:0]     out_addr_reg;

    itf_pkg::scan_state_t          scan_nxt;
    itf_pkg::scan_result_t         scan_res;

    logic                          out_free;
    logic                          advance;
    logic                          take;

    // per-byte update of the run tracker
    itf_scan u_scan (
        .cur       (state_reg),
        .text_byte (in_byte_reg),
        .text_end  (in_end_reg),
        .nxt       (scan_nxt),
        .res       (scan_res)
    );

    // the result register is free when empty or drained this cycle
    assign out_free = !out_vld_reg || result.ready;

    // the held byte moves on unless it makes a result with nowhere to go
    assign advance  = in_vld_reg && (!scan_res.emit || out_free);

    assign text.ready = !in_vld_reg || advance;
    assign take       = text.valid && text.ready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (take)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (advance)
        begin
            state_next = scan_nxt;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (advance && scan_res.emit)
        begin
            out_vld_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            state_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg <= text.text_byte;
            in_end_reg  <= text.text_end;
        end
        if (advance && scan_res.emit)
        begin
            out_found_reg <= scan_res.found;
            out_addr_reg  <= scan_res.address;
        end
    end

    assign result.valid   = out_vld_reg;
    assign result.found   = out_found_reg;
    assign result.address = out_addr_reg;

endmodule

// File: sv/itf_checker.sv
`include "ipv4_text_finder_assert.svh"

module itf_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      found,
    input logic [itf_pkg::AddrW-1:0] address
);

    // a stalled result transaction holds
    `ITF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(found) && $stable(address))

    // the not-found result carries a zero address
    `ITF_ASSERT_NOW(a_notfound_zero, out_valid && !found, address == '0)

    // with the output empty nothing blocks the input
    `ITF_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

    // a waiting input transaction is held back only by a stalled result
    `ITF_ASSERT_NOW(a_stall_when_full, in_valid && !in_ready, out_valid && !out_ready)

endmodule

bind ipv4_text_finder itf_checker u_itf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (text.valid),
    .in_ready  (text.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .found     (result.found),
    .address   (result.address)
);

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // one report as it should leave the block
    typedef struct packed {
        logic                      found;
        logic [itf_pkg::AddrW-1:0] address;
    } hit_t;

    // mirror of the block's scan state, updated once per accepted byte
    typedef struct packed {
        logic        in_run;
        logic [4:0]  run_len;
        logic [2:0]  segs_closed;
        logic [9:0]  seg_value;
        logic [1:0]  seg_digits;
        logic [3:0]  dot_run;
        logic        bad;
        logic [23:0] octets;
        logic        reported;
    } scan_t;

    logic clk;
    logic rst_n;

    itf_in_if  text_ch ();
    itf_out_if result_ch ();

    ipv4_text_finder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (result_ch)
    );

    scan_t          scan;
    hit_t           pending_reports[$];   // expected reports, oldest first
    logic [7:0]     text_buf[$];          // text being built for the next send
    int unsigned    sent_bytes;           // accepted byte transactions
    int unsigned    mismatches;
    bit             tx_calm;              // sender runs without gaps
    bit             rx_calm;              // receiver runs without stalls

    // free-running clock, 4 ns period
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // address scanner prediction
    // ------------------------------------------------------------------

    function automatic void grow_run();
        if (scan.run_len < itf_pkg::RunSat)
            scan.run_len = scan.run_len + 5'd1;
    endfunction

    function automatic void take_digit(input logic [3:0] d);
        if (!scan.in_run)
        begin
            // first digit opens a new run
            scan.in_run      = 1'b1;
            scan.run_len     = 5'd1;
            scan.segs_closed = 3'd0;
            scan.seg_value   = 10'(d);
            scan.seg_digits  = 2'd1;
            scan.dot_run     = 4'd0;
            scan.bad         = 1'b0;
            scan.octets      = 24'd0;
            return;
        end
        grow_run();
        if (scan.dot_run != 4'd0)
        begin
            // digit after dots closes the previous segment
            if (scan.dot_run > 4'd1)
                scan.bad = 1'b1;
            if (scan.seg_value > itf_pkg::OctetMax)
                scan.bad = 1'b1;
            if (scan.segs_closed >= itf_pkg::SegLast)
                scan.bad = 1'b1;
            else
            begin
                scan.octets      = {scan.octets[15:0], scan.seg_value[7:0]};
                scan.segs_closed = scan.segs_closed + 3'd1;
            end
            scan.seg_value  = 10'(d);
            scan.seg_digits = 2'd1;
            scan.dot_run    = 4'd0;
        end
        else if (scan.seg_digits >= itf_pkg::SegDigitsMax)
            scan.bad = 1'b1;
        else
        begin
            scan.seg_value  = 10'(scan.seg_value * 10 + d);
            scan.seg_digits = scan.seg_digits + 2'd1;
        end
    endfunction

    // judge the open run and drop it; the address is built either way
    function automatic bit close_run(output logic [itf_pkg::AddrW-1:0] addr);
        bit      ok;
        logic    keep;
        ok = scan.in_run && !scan.bad &&
             scan.run_len >= itf_pkg::RunMin && scan.run_len <= itf_pkg::RunMax &&
             scan.segs_closed == itf_pkg::SegLast &&
             scan.seg_digits != 2'd0 && scan.seg_value <= itf_pkg::OctetMax;
        addr = {scan.octets, scan.seg_value[7:0]};
        keep = scan.reported;
        scan = '0;
        scan.reported = keep;
        return ok;
    endfunction

    function automatic void scan_for_address(input logic [7:0] ch, input logic last,
                                             output bit emits, output hit_t hit);
        bit                        is_addr;
        logic [itf_pkg::AddrW-1:0] addr;
        emits   = 1'b0;
        hit     = '0;
        is_addr = 1'b0;
        addr    = '0;
        if (scan.reported)
        begin
            // text already answered, wait for its end
            if (last)
                scan = '0;
            return;
        end
        if (ch >= itf_pkg::CharZero && ch <= itf_pkg::CharNine)
            take_digit(4'(ch - itf_pkg::CharZero));
        else if (ch == itf_pkg::CharDot)
        begin
            if (scan.in_run)
            begin
                grow_run();
                if (scan.dot_run < itf_pkg::DotsSat)
                    scan.dot_run = scan.dot_run + 4'd1;
            end
        end
        else if (scan.in_run)
            is_addr = close_run(addr);
        // a run still open at the last byte is judged there
        if (!is_addr && last && scan.in_run)
            is_addr = close_run(addr);
        if (is_addr)
        begin
            emits       = 1'b1;
            hit.found   = 1'b1;
            hit.address = addr;
            if (last)
                scan = '0;
            else
                scan.reported = 1'b1;
        end
        else if (last)
        begin
            // not-found report closes the text
            emits = 1'b1;
            scan  = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // one byte transaction; valid stays high when the next byte follows at once
    task automatic send_byte(input logic [7:0] ch, input logic last);
        int unsigned gap;
        bit          emits;
        hit_t        hit;
        gap = tx_calm ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= ch;
        text_ch.text_end  <= last;
        do
            @(posedge clk);
        while (!text_ch.ready);
        scan_for_address(ch, last, emits, hit);
        if (emits)
            pending_reports.push_back(hit);
        sent_bytes++;
    endtask

    // send the built text, flagging its last byte as the end
    task automatic send_text();
        int i;
        for (i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    // sender holds off until the block has handed out every report
    task automatic hold_until_drained();
        text_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_reports.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // text builders
    // ------------------------------------------------------------------

    function automatic void put_string(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endfunction

    // decimal with leading zeros up to the given digit count
    function automatic void put_number(input int unsigned value, input int unsigned digits);
        int unsigned scale;
        scale = 1;
        repeat (digits - 1) scale = scale * 10;
        repeat (digits)
        begin
            text_buf.push_back(8'(itf_pkg::CharZero + (value / scale) % 10));
            scale = scale / 10;
        end
    endfunction

    // any byte, leaning toward digits and dots now and then
    function automatic logic [7:0] noise_byte();
        int unsigned r;
        if ($urandom_range(0, 3) == 0)
        begin
            r = $urandom_range(0, 10);
            return (r == 10) ? itf_pkg::CharDot : 8'(itf_pkg::CharZero + r);
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // a byte that is neither digit nor dot, so it always ends a run
    function automatic logic [7:0] break_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while ((b >= itf_pkg::CharZero && b <= itf_pkg::CharNine) || b == itf_pkg::CharDot);
        return b;
    endfunction

    // dotted quad, often clean, otherwise broken in one or more ways
    function automatic void put_candidate();
        int unsigned kind;
        int unsigned segs;
        int unsigned bad_seg;
        int unsigned value;
        int unsigned digits;
        int unsigned dots;
        int unsigned i;
        kind    = $urandom_range(0, 11);
        segs    = (kind == 6) ? $urandom_range(2, 6) : 4;
        bad_seg = $urandom_range(0, segs - 1);
        for (i = 0; i < segs; i++)
        begin
            case ($urandom_range(0, 3))
                0:       value = 0;
                1:       value = 255;
                default: value = $urandom_range(0, 255);
            endcase
            if (kind == 7 && i == bad_seg)
                value = $urandom_range(256, 999);
            digits = (value > 99) ? 3 : (value > 9) ? 2 : 1;
            if ($urandom_range(0, 4) == 0)
                digits = $urandom_range(digits, 3);
            if (kind == 8 && i == bad_seg)
                digits = $urandom_range(4, 5);
            put_number(value, digits);
            if (i != segs - 1)
            begin
                dots = (kind == 9 && i == bad_seg) ? $urandom_range(2, 3) : 1;
                repeat (dots) text_buf.push_back(itf_pkg::CharDot);
            end
        end
        // trailing dots, sometimes enough to push the run past its limit
        if (kind == 10 || $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 9)) text_buf.push_back(itf_pkg::CharDot);
        // long digit and dot tail to saturate the run counter
        if (kind == 11)
            repeat ($urandom_range(1, 20))
                text_buf.push_back(($urandom_range(0, 3) == 0) ?
                                   itf_pkg::CharDot :
                                   8'(itf_pkg::CharZero + $urandom_range(0, 9)));
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // dot before the run, shortest address, trailing dot, run closed by the end
    task automatic test_shortest_address();
        put_string(".0.0.0.0.");
        send_text();
    endtask

    // all-ones address, then a byte the block must ignore up to the end
    task automatic test_widest_address();
        put_string("255.255.255.255");
        text_buf.push_back(8'hFF);
        put_string("7");
        send_text();
    endtask

    // double dot, fifth segment and four-digit segment in one run, no address
    task automatic test_broken_run();
        put_string("1..2.3.4.5555");
        text_buf.push_back(8'h00);
        send_text();
    endtask

    task automatic test_random_texts(input int unsigned target);
        int unsigned first;
        int unsigned texts;
        first = sent_bytes;
        texts = 0;
        while (sent_bytes - first < target)
        begin
            // switch between idling and back-to-back stretches
            if (texts % 16 == 0)
            begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            repeat ($urandom_range(0, 3)) text_buf.push_back(noise_byte());
            repeat (($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 2))
            begin
                put_candidate();
                if ($urandom_range(0, 2) != 0)
                    text_buf.push_back(break_byte());
            end
            repeat ($urandom_range(0, 3)) text_buf.push_back(noise_byte());
            if (text_buf.size() == 0)
                text_buf.push_back(noise_byte());
            send_text();
            texts++;
            if (texts % 40 == 0)
                hold_until_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------

    // receiver draws a stall before each result transaction
    initial
    begin : result_taker
        int unsigned stall;
        forever
        begin
            stall = rx_calm ? 0 : $urandom_range(0, 14);
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
        end
    end

    // every result transaction against the oldest expected report
    always @(posedge clk)
    begin : report_check
        hit_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: unexpected report found=%0b address=%h",
                         $time, result_ch.found, result_ch.address);
                mismatches++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (result_ch.found !== want.found)
                begin
                    $display("%0t: found expected %0b actual %0b",
                             $time, want.found, result_ch.found);
                    mismatches++;
                end
                if (result_ch.address !== want.address)
                begin
                    $display("%0t: address expected %h actual %h",
                             $time, want.address, result_ch.address);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin : main_flow
        int unsigned waited;
        scan       = '0;
        sent_bytes = 0;
        mismatches = 0;
        tx_calm    = 1'b0;
        rx_calm    = 1'b0;
        rst_n             <= 1'b0;
        text_ch.valid     <= 1'b0;
        text_ch.text_byte <= '0;
        text_ch.text_end  <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_shortest_address();
        test_widest_address();
        test_broken_run();
        test_random_texts(1950);

        // drain, then leave room for a stray late result
        text_ch.valid <= 1'b0;
        waited = 0;
        while (pending_reports.size() != 0 && waited < 500)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (16) @(posedge clk);
        if (pending_reports.size() != 0)
            $display("%0t: %0d reports never arrived", $time, pending_reports.size());
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // run limit, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("%0t: run limit reached", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
